// ===== hdl/dvs_pkg.sv =====
// Shared types, constants and decode functions for the drum voice synthesizer.
// Used by the channel interfaces and the top level.
package dvs_pkg;

    localparam int DEF_VOICES          = 8;
    localparam int DEF_SINE_TABLE_BITS = 10;
    localparam int DEF_AGE_BITS        = 20;

    localparam int INV_W      = 20;
    localparam int ENV_W      = 24;
    localparam int DEC_W      = 24;
    localparam int SAMP_W     = 16;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int SOUND_W    = 4;
    localparam int GAIN_W     = 16;
    localparam int FREQ_W     = 24;
    localparam int NOISE_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [INV_W-1:0] INV_RATE_RST     = 20'd89478;
    localparam logic [DEC_W-1:0] DECAY_KICK_RST   = 24'd16772848;
    localparam logic [DEC_W-1:0] DECAY_CLOSED_RST = 24'd16768480;
    localparam logic [DEC_W-1:0] DECAY_OPEN_RST   = 24'd16774304;
    localparam logic [DEC_W-1:0] DECAY_CRASH_RST  = 24'd16776051;
    localparam logic [DEC_W-1:0] DECAY_OTHER_RST  = 24'd16773721;

    localparam logic [ENV_W-1:0]   ENV_FULL   = 24'hFFFFFF;
    localparam logic [ENV_W-1:0]   ENV_FLOOR  = 24'd16778;
    localparam logic [NOISE_W-1:0] NOISE_SEED = 32'h12345678;
    localparam logic [NOISE_W-1:0] NOISE_MASK = 32'h80200003;

    localparam logic [GAIN_W-1:0] GAIN_ONE  = 16'd32768;
    localparam logic [GAIN_W-1:0] GAIN_HALF = 16'd16384;
    localparam logic [GAIN_W-1:0] GAIN_40   = 16'd13107;
    localparam logic [GAIN_W-1:0] GAIN_30   = 16'd9830;

    // Frequencies in Q8.16 hertz.
    localparam logic [FREQ_W-1:0] FREQ_SNARE   = 24'd14417920;
    localparam logic [FREQ_W-1:0] FREQ_MID_TOM = 24'd6061989;
    localparam logic [FREQ_W-1:0] FREQ_LOW_TOM = 24'd6804352;
    localparam logic [FREQ_W-1:0] FREQ_HI_TOM  = 24'd7637627;
    localparam logic [FREQ_W-1:0] FREQ_KICK_HI = 24'd5242880;
    localparam logic [FREQ_W-1:0] FREQ_KICK_LO = 24'd2621440;

    // Quarter-wave sine polynomial coefficients, Q15.
    localparam logic [15:0] SIN_A = 16'd51470;
    localparam logic [14:0] SIN_B = 15'd21077;
    localparam logic [11:0] SIN_C = 12'd2383;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_RATE,
        CFG_DECAY_KICK,
        CFG_DECAY_CLOSED,
        CFG_DECAY_OPEN,
        CFG_DECAY_CRASH,
        CFG_DECAY_OTHER
    } cfg_index_t;

    typedef enum logic [SOUND_W-1:0] {
        SND_KICK,
        SND_SNARE,
        SND_CLOSED_HAT,
        SND_CLAP,
        SND_OPEN_HAT,
        SND_MID_TOM,
        SND_LOW_TOM,
        SND_HI_TOM,
        SND_CRASH
    } sound_t;

    typedef enum logic [2:0] {
        DEC_KICK,
        DEC_CLOSED,
        DEC_OPEN,
        DEC_CRASH,
        DEC_OTHER
    } decay_sel_t;

    typedef struct packed {
        logic                is_kick;
        logic                has_noise;
        logic                has_sine;
        logic [GAIN_W-1:0]   gain_noise;
        logic [GAIN_W-1:0]   gain_sine;
        logic [FREQ_W-1:0]   freq;
        decay_sel_t          decay_sel;
    } sound_props_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_AGE,
        S_FREQ,
        S_PLO,
        S_PHI,
        S_SX2,
        S_SIN,
        S_SMID,
        S_SR,
        S_GN,
        S_TN,
        S_GS,
        S_TS,
        S_WB,
        S_DONE
    } dvs_state_t;

    function automatic logic [SOUND_W-1:0] sound_of(input logic [NOTE_W-1:0] note);
        sound_t s;
        case (note)
            7'd37:   s = SND_SNARE;
            7'd38:   s = SND_CLOSED_HAT;
            7'd39:   s = SND_CLAP;
            7'd40:   s = SND_OPEN_HAT;
            7'd42:   s = SND_MID_TOM;
            7'd44:   s = SND_LOW_TOM;
            7'd46:   s = SND_HI_TOM;
            7'd48:   s = SND_CRASH;
            default: s = SND_KICK;
        endcase
        return s;
    endfunction

    function automatic sound_props_t sound_props(input logic [SOUND_W-1:0] code);
        sound_props_t p;
        p = '{is_kick: 1'b0, has_noise: 1'b0, has_sine: 1'b0, gain_noise: '0,
              gain_sine: '0, freq: '0, decay_sel: DEC_OTHER};
        case (code)
            SND_SNARE:
            begin
                p.has_noise  = 1'b1;
                p.gain_noise = GAIN_HALF;
                p.has_sine   = 1'b1;
                p.gain_sine  = GAIN_30;
                p.freq       = FREQ_SNARE;
            end
            SND_CLOSED_HAT:
            begin
                p.has_noise  = 1'b1;
                p.gain_noise = GAIN_40;
                p.decay_sel  = DEC_CLOSED;
            end
            SND_CLAP:
            begin
                p.has_noise  = 1'b1;
                p.gain_noise = GAIN_HALF;
            end
            SND_OPEN_HAT:
            begin
                p.has_noise  = 1'b1;
                p.gain_noise = GAIN_40;
                p.decay_sel  = DEC_OPEN;
            end
            SND_MID_TOM:
            begin
                p.has_sine  = 1'b1;
                p.gain_sine = GAIN_HALF;
                p.freq      = FREQ_MID_TOM;
            end
            SND_LOW_TOM:
            begin
                p.has_sine  = 1'b1;
                p.gain_sine = GAIN_HALF;
                p.freq      = FREQ_LOW_TOM;
            end
            SND_HI_TOM:
            begin
                p.has_sine  = 1'b1;
                p.gain_sine = GAIN_HALF;
                p.freq      = FREQ_HI_TOM;
            end
            SND_CRASH:
            begin
                p.has_noise  = 1'b1;
                p.gain_noise = GAIN_30;
                p.decay_sel  = DEC_CRASH;
            end
            default:
            begin
                p.is_kick   = 1'b1;
                p.has_sine  = 1'b1;
                p.gain_sine = GAIN_ONE;
                p.freq      = FREQ_KICK_HI;
                p.decay_sel = DEC_KICK;
            end
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/dvs_if.sv =====
// Valid/ready channel interfaces for note/tick requests and stereo results.
// Field widths come from dvs_pkg.
interface dvs_req_if;
    import dvs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [NOTE_W-1:0]        note;
    logic [VEL_W-1:0]         velocity;
    logic signed [SAMP_W-1:0] left_in;
    logic signed [SAMP_W-1:0] right_in;
    modport source (output valid, kind, note, velocity, left_in, right_in, input ready);
    modport sink (input valid, kind, note, velocity, left_in, right_in, output ready);
endinterface

interface dvs_rsp_if;
    import dvs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [SAMP_W-1:0] left_out;
    logic signed [SAMP_W-1:0] right_out;
    modport source (output valid, left_out, right_out, input ready);
    modport sink (input valid, left_out, right_out, output ready);
endinterface

// ===== hdl/dvs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/drum_voice_synthesizer.sv =====
// Drum voice synthesizer: a note request gives no result.
// A tick request walks every voice and gives one stereo result; noise-only sounds skip the
// sine states, and the result waits in S_DONE until the previous result has been taken;
// the shared sequencer walks the voice RAM one voice at a time and all multiplies of one
// voice run through it in turn.
// Reset: all voices idle, configuration at defaults, noise LFSR at its seed; voice RAM
// contents are only used for active voices, so it needs no clearing.
module drum_voice_synthesizer
    import dvs_pkg::*;
#(
    parameter int VOICES          = dvs_pkg::DEF_VOICES,
    parameter int SINE_TABLE_BITS = dvs_pkg::DEF_SINE_TABLE_BITS,
    parameter int AGE_BITS        = dvs_pkg::DEF_AGE_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [dvs_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [dvs_pkg::CFG_DATA_W-1:0]  wr_data,
    dvs_req_if.sink                         req,
    dvs_rsp_if.source                       rsp
);

    localparam int VW     = $clog2(VOICES);
    localparam int RAM_W  = SOUND_W + AGE_BITS + ENV_W;
    localparam int TS_W   = AGE_BITS + INV_W;
    localparam int HI_W   = TS_W - 24;
    localparam int DROP_W = TS_W + 9 - 16;
    localparam int SUM_W  = SAMP_W + VW + 3;
    localparam int ACC_W  = 19;
    localparam int QW     = SINE_TABLE_BITS - 1;
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
    localparam logic [QW-1:0] QUARTER = QW'(1) << (SINE_TABLE_BITS - 2);

    dvs_state_t state_reg, state_next;
    logic [VW-1:0]      v_reg, v_next;
    logic [VOICES-1:0]  active_reg, active_next;
    logic [NOISE_W-1:0] noise_reg, noise_next;
    logic               out_valid_reg, out_valid_next;
    logic [INV_W-1:0]   inv_rate_reg, inv_rate_next;
    logic [DEC_W-1:0]   dec_kick_reg, dec_kick_next;
    logic [DEC_W-1:0]   dec_closed_reg, dec_closed_next;
    logic [DEC_W-1:0]   dec_open_reg, dec_open_next;
    logic [DEC_W-1:0]   dec_crash_reg, dec_crash_next;
    logic [DEC_W-1:0]   dec_other_reg, dec_other_next;

    logic signed [SAMP_W-1:0] left_reg, left_next, right_reg, right_next;
    logic signed [SAMP_W-1:0] out_left_reg, out_left_next, out_right_reg, out_right_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    sound_props_t             props_reg, props_next;
    logic [SOUND_W-1:0]       sound_reg, sound_next;
    logic [AGE_BITS-1:0]      age_reg, age_next;
    logic [ENV_W-1:0]         env_reg, env_next, env_new_reg, env_new_next;
    logic [TS_W-1:0]          ts_reg, ts_next;
    logic [FREQ_W-1:0]        freq_reg, freq_next;
    logic [47:0]              plo_reg, plo_next;
    logic [31:0]              phase_reg, phase_next;
    logic [15:0]              x_reg, x_next, x2_reg, x2_next;
    logic                     sine_neg_reg, sine_neg_next;
    logic [14:0]              inner_reg, inner_next;
    logic [15:0]              mid_reg, mid_next;
    logic [14:0]              sine_mag_reg, sine_mag_next;
    logic signed [SAMP_W-1:0] noise_val_reg, noise_val_next;
    logic [ENV_W-1:0]         g_reg, g_next;

    logic             ram_wr_en, ram_rd_en;
    logic [VW-1:0]    ram_wr_addr;
    logic [RAM_W-1:0] ram_wr_data, ram_rd_data;

    dvs_ram #(
        .WIDTH (RAM_W),
        .DEPTH (VOICES)
    ) u_voice_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (v_reg),
        .rd_data (ram_rd_data)
    );

    // Combinational helpers
    logic [VW-1:0]            slot;
    logic [SOUND_W-1:0]       rd_sound;
    logic [AGE_BITS-1:0]      rd_age;
    logic [ENV_W-1:0]         rd_env;
    logic [AGE_BITS-1:0]      age_inc;
    logic [NOISE_W-1:0]       noise_step;
    logic [TS_W+8:0]          ts400;
    logic [DROP_W-1:0]        drop;
    logic [DEC_W-1:0]         decay;
    logic [47:0]              env_prod;
    logic [HI_W+FREQ_W-1:0]   phi_prod;
    logic [47:0]              phase_sum;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [QW-1:0]            qq;
    logic [15:0]              x_c;
    logic [31:0]              sq_prod;
    logic [27:0]              c_prod;
    logic [30:0]              in_prod;
    logic [31:0]              r_prod;
    logic [39:0]              g_prod;
    logic [GAIN_W-1:0]        gain;
    logic [16:0]              mag;
    logic                     neg;
    logic [40:0]              t_prod;
    logic signed [ACC_W-1:0]  term;
    logic signed [SUM_W:0]    mix_l, mix_r;
    logic signed [SAMP_W-1:0] sat_l, sat_r;

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.left_out  = out_left_reg;
    assign rsp.right_out = out_right_reg;
    assign ram_rd_en     = (state_reg == S_READ);

    always_comb
    begin
        slot = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                slot = VW'(i);
            end
        end

        {rd_sound, rd_age, rd_env} = ram_rd_data;
        age_inc = (rd_age < AGE_MAX) ? rd_age + AGE_BITS'(1) : rd_age;

        noise_step = {1'b0, noise_reg[NOISE_W-1:1]} ^ (noise_reg[0] ? NOISE_MASK : '0);

        ts400 = ({9'd0, ts_reg} << 8) + ({9'd0, ts_reg} << 7) + ({9'd0, ts_reg} << 4);
        drop  = ts400[TS_W+8:16];

        case (props_reg.decay_sel)
            DEC_KICK:   decay = dec_kick_reg;
            DEC_CLOSED: decay = dec_closed_reg;
            DEC_OPEN:   decay = dec_open_reg;
            DEC_CRASH:  decay = dec_crash_reg;
            default:    decay = dec_other_reg;
        endcase
        env_prod = env_reg * decay;

        phi_prod  = ts_reg[TS_W-1:24] * freq_reg;
        phase_sum = plo_reg + {phi_prod[23:0], 24'd0};

        // Quarter-wave fold of the table index.
        idx     = phase_reg[31 -: SINE_TABLE_BITS];
        qq      = idx[SINE_TABLE_BITS-2] ? QUARTER - {1'b0, idx[SINE_TABLE_BITS-3:0]}
                                         : {1'b0, idx[SINE_TABLE_BITS-3:0]};
        x_c     = 16'(qq) << (17 - SINE_TABLE_BITS);
        sq_prod = x_c * x_c;
        c_prod  = SIN_C * x2_reg;
        in_prod = inner_reg * x2_reg;
        r_prod  = mid_reg * x_reg;

        gain   = (state_reg == S_GN) ? props_reg.gain_noise : props_reg.gain_sine;
        g_prod = env_reg * gain;

        if (state_reg == S_TN)
        begin
            neg = noise_val_reg[SAMP_W-1];
            mag = neg ? (~{1'b1, noise_val_reg} + 17'd1) : {1'b0, noise_val_reg};
        end
        else
        begin
            neg = sine_neg_reg;
            mag = {2'b00, sine_mag_reg};
        end
        t_prod = mag * g_reg;
        term   = neg ? -ACC_W'($signed({2'b00, t_prod[40:24]}))
                     : ACC_W'($signed({2'b00, t_prod[40:24]}));

        mix_l = (SUM_W+1)'(left_reg) + (SUM_W+1)'(sum_reg);
        mix_r = (SUM_W+1)'(right_reg) + (SUM_W+1)'(sum_reg);
        if (mix_l > (SUM_W+1)'(32767))
        begin
            sat_l = 16'sh7FFF;
        end
        else if (mix_l < -(SUM_W+1)'(32768))
        begin
            sat_l = -16'sh8000;
        end
        else
        begin
            sat_l = mix_l[SAMP_W-1:0];
        end
        if (mix_r > (SUM_W+1)'(32767))
        begin
            sat_r = 16'sh7FFF;
        end
        else if (mix_r < -(SUM_W+1)'(32768))
        begin
            sat_r = -16'sh8000;
        end
        else
        begin
            sat_r = mix_r[SAMP_W-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        v_next          = v_reg;
        active_next     = active_reg;
        noise_next      = noise_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        inv_rate_next   = inv_rate_reg;
        dec_kick_next   = dec_kick_reg;
        dec_closed_next = dec_closed_reg;
        dec_open_next   = dec_open_reg;
        dec_crash_next  = dec_crash_reg;
        dec_other_next  = dec_other_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;
        sum_next        = sum_reg;
        acc_next        = acc_reg;
        props_next      = props_reg;
        sound_next      = sound_reg;
        age_next        = age_reg;
        env_next        = env_reg;
        env_new_next    = env_new_reg;
        ts_next         = ts_reg;
        freq_next       = freq_reg;
        plo_next        = plo_reg;
        phase_next      = phase_reg;
        x_next          = x_reg;
        x2_next         = x2_reg;
        sine_neg_next   = sine_neg_reg;
        inner_next      = inner_reg;
        mid_next        = mid_reg;
        sine_mag_next   = sine_mag_reg;
        noise_val_next  = noise_val_reg;
        g_next          = g_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = v_reg;
        ram_wr_data     = {sound_reg, age_reg, env_new_reg};

        if (wr_en)
        begin
            case (wr_index)
                CFG_INV_RATE:     inv_rate_next   = wr_data[INV_W-1:0];
                CFG_DECAY_KICK:   dec_kick_next   = wr_data;
                CFG_DECAY_CLOSED: dec_closed_next = wr_data;
                CFG_DECAY_OPEN:   dec_open_next   = wr_data;
                CFG_DECAY_CRASH:  dec_crash_next  = wr_data;
                CFG_DECAY_OTHER:  dec_other_next  = wr_data;
                default:          ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.kind)
                    begin
                        left_next  = req.left_in;
                        right_next = req.right_in;
                        sum_next   = '0;
                        v_next     = '0;
                        state_next = S_READ;
                    end
                    else if (req.velocity != '0)
                    begin
                        active_next[slot] = 1'b1;
                        ram_wr_en         = 1'b1;
                        ram_wr_addr       = slot;
                        ram_wr_data       = {sound_of(req.note), AGE_BITS'(0), ENV_FULL};
                    end
                end
            end
            S_READ:
            begin
                if (active_reg[v_reg])
                begin
                    state_next = S_AGE;
                end
                else if (v_reg == VW'(VOICES - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    v_next = v_reg + VW'(1);
                end
            end
            S_AGE:
            begin
                sound_next = rd_sound;
                props_next = sound_props(rd_sound);
                age_next   = age_inc;
                env_next   = rd_env;
                ts_next    = age_inc * inv_rate_reg;
                acc_next   = '0;
                // The noise source steps only for voices that use it, in voice order.
                if (props_next.has_noise)
                begin
                    noise_next     = noise_step;
                    noise_val_next = {~noise_step[31], noise_step[30:16]};
                end
                state_next = S_FREQ;
            end
            S_FREQ:
            begin
                if (props_reg.is_kick)
                begin
                    freq_next = (drop >= DROP_W'(FREQ_KICK_LO)) ? FREQ_KICK_LO
                                : FREQ_KICK_HI - drop[FREQ_W-1:0];
                end
                else
                begin
                    freq_next = props_reg.freq;
                end
                env_new_next = env_prod[47:24];
                if (props_reg.has_sine)
                begin
                    state_next = S_PLO;
                end
                else
                begin
                    state_next = S_GN;
                end
            end
            S_PLO:
            begin
                plo_next   = ts_reg[23:0] * freq_reg;
                state_next = S_PHI;
            end
            S_PHI:
            begin
                phase_next = phase_sum[47:16];
                state_next = S_SX2;
            end
            S_SX2:
            begin
                x_next        = x_c;
                x2_next       = sq_prod[30:15];
                sine_neg_next = idx[SINE_TABLE_BITS-1];
                state_next    = S_SIN;
            end
            S_SIN:
            begin
                inner_next = SIN_B - {2'b00, c_prod[27:15]};
                state_next = S_SMID;
            end
            S_SMID:
            begin
                mid_next   = SIN_A - in_prod[30:15];
                state_next = S_SR;
            end
            S_SR:
            begin
                sine_mag_next = (r_prod[31:15] > 17'd32767) ? 15'h7FFF : r_prod[29:15];
                if (props_reg.has_noise)
                begin
                    state_next = S_GN;
                end
                else
                begin
                    state_next = S_GS;
                end
            end
            S_GN:
            begin
                g_next     = g_prod[38:15];
                state_next = S_TN;
            end
            S_TN:
            begin
                acc_next = acc_reg + term;
                if (props_reg.has_sine)
                begin
                    state_next = S_GS;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_GS:
            begin
                g_next     = g_prod[38:15];
                state_next = S_TS;
            end
            S_TS:
            begin
                acc_next   = acc_reg + term;
                state_next = S_WB;
            end
            S_WB:
            begin
                ram_wr_en = 1'b1;
                // A voice whose envelope falls under the floor stops and drops its value.
                if (env_new_reg < ENV_FLOOR)
                begin
                    active_next[v_reg] = 1'b0;
                end
                else
                begin
                    sum_next = sum_reg + SUM_W'(acc_reg);
                end
                if (v_reg == VW'(VOICES - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    v_next     = v_reg + VW'(1);
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_left_next  = sat_l;
                    out_right_next = sat_r;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            v_reg          <= '0;
            active_reg     <= '0;
            noise_reg      <= NOISE_SEED;
            out_valid_reg  <= 1'b0;
            inv_rate_reg   <= INV_RATE_RST;
            dec_kick_reg   <= DECAY_KICK_RST;
            dec_closed_reg <= DECAY_CLOSED_RST;
            dec_open_reg   <= DECAY_OPEN_RST;
            dec_crash_reg  <= DECAY_CRASH_RST;
            dec_other_reg  <= DECAY_OTHER_RST;
        end
        else
        begin
            state_reg      <= state_next;
            v_reg          <= v_next;
            active_reg     <= active_next;
            noise_reg      <= noise_next;
            out_valid_reg  <= out_valid_next;
            inv_rate_reg   <= inv_rate_next;
            dec_kick_reg   <= dec_kick_next;
            dec_closed_reg <= dec_closed_next;
            dec_open_reg   <= dec_open_next;
            dec_crash_reg  <= dec_crash_next;
            dec_other_reg  <= dec_other_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg      <= left_next;
        right_reg     <= right_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        sum_reg       <= sum_next;
        acc_reg       <= acc_next;
        props_reg     <= props_next;
        sound_reg     <= sound_next;
        age_reg       <= age_next;
        env_reg       <= env_next;
        env_new_reg   <= env_new_next;
        ts_reg        <= ts_next;
        freq_reg      <= freq_next;
        plo_reg       <= plo_next;
        phase_reg     <= phase_next;
        x_reg         <= x_next;
        x2_reg        <= x2_next;
        sine_neg_reg  <= sine_neg_next;
        inner_reg     <= inner_next;
        mid_reg       <= mid_next;
        sine_mag_reg  <= sine_mag_next;
        noise_val_reg <= noise_val_next;
        g_reg         <= g_next;
    end

    // A new result is only raised by the end of a tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside tick completion");

    // A nonzero-velocity note always leaves at least one voice running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && !req.kind && req.velocity != '0) |=> (active_reg != '0))
        else $error("note request started no voice");

    // The LFSR must never lock up at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        noise_reg != '0)
        else $error("noise register reached zero");

    // A voice only enters processing while it is active.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AGE) |-> active_reg[v_reg])
        else $error("inactive voice entered processing");

endmodule
